// ----- src/dcrb_pkg.sv -----
// shared types and constants of the disk controller register block
`timescale 1ns / 1ps

package dcrb_pkg;

    localparam int CMD_W   = 2;
    localparam int REG_W   = 3;
    localparam int DATA_W  = 16;
    localparam int UNIT_W  = 2;
    localparam int DELAY_W = 4;
    localparam int SECT_W  = 13;
    localparam int BA_W    = 18;

    // item commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MEDIA = 2'd3;

    // register indexes
    localparam logic [REG_W-1:0] REG_STATUS  = 3'd0;
    localparam logic [REG_W-1:0] REG_ERROR   = 3'd1;
    localparam logic [REG_W-1:0] REG_CONTROL = 3'd2;
    localparam logic [REG_W-1:0] REG_WCOUNT  = 3'd3;
    localparam logic [REG_W-1:0] REG_BUSADDR = 3'd4;
    localparam logic [REG_W-1:0] REG_DISKADR = 3'd5;
    localparam logic [REG_W-1:0] REG_MAINT   = 3'd6;
    localparam logic [REG_W-1:0] REG_DATABUF = 3'd7;

    // function codes
    localparam logic [2:0] FN_CTRL_RESET = 3'd0;
    localparam logic [2:0] FN_WRITE      = 3'd1;
    localparam logic [2:0] FN_READ       = 3'd2;

    localparam logic [DATA_W-1:0] ERR_NXD      = 16'h0080;
    localparam logic [DATA_W-1:0] ERR_NXC      = 16'h0040;
    localparam logic [DATA_W-1:0] ERR_NXS      = 16'h0020;
    localparam logic [DATA_W-1:0] CS_ERR       = 16'h8000;
    localparam logic [DATA_W-1:0] CS_RDY       = 16'h0080;
    localparam logic [DATA_W-1:0] CS_KEEP_MASK = 16'hF000;
    localparam logic [DATA_W-1:0] CS_WR_MASK   = 16'h0FFF;
    localparam logic [DATA_W-1:0] STATUS_BASE  = 16'h0840;
    localparam logic [DATA_W-1:0] STATUS_MNT   = 16'h0080;
    localparam int               CS_IE_BIT    = 6;
    localparam logic [7:0]        MAX_CYL      = 8'd202;
    localparam logic [3:0]        SECS         = 4'd12;
    // 171 / 2048 approximates 1/12 for sector sums up to 266
    localparam logic [7:0]        DIV12_MUL    = 8'd171;
    localparam logic [DELAY_W-1:0] IRQ_DELAY_RST = 4'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [REG_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [UNIT_W-1:0] drive_unit;
        logic              media_mounted;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_request;
        logic              irq_cancel;
        logic              xfer_valid;
        logic              xfer_write;
        logic [SECT_W-1:0] xfer_sector;
        logic [BA_W-1:0]   xfer_bus_addr;
        logic [DATA_W-1:0] xfer_words;
    } result_t;

    // what the address unit reports for one read or write function
    typedef struct packed {
        logic              err_nxc;
        logic              err_nxs;
        logic              zero_words;
        logic [SECT_W-1:0] sector;
        logic [BA_W-1:0]   start_addr;
        logic [DATA_W-1:0] words;
        logic [DATA_W-1:0] next_wcount;
        logic [BA_W-1:0]   next_addr;
        logic [DATA_W-1:0] next_disk_addr;
    } xfer_calc_t;

endpackage

// ----- src/dcrb_if.sv -----
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface dcrb_req_if;
    logic                         valid;
    logic                         ready;
    logic [dcrb_pkg::CMD_W-1:0]   cmd;
    logic [dcrb_pkg::REG_W-1:0]   reg_index;
    logic [dcrb_pkg::DATA_W-1:0]  write_data;
    logic [dcrb_pkg::UNIT_W-1:0]  drive_unit;
    logic                         media_mounted;

    modport source (output valid, cmd, reg_index, write_data, drive_unit, media_mounted,
                    input ready);
    modport sink (input valid, cmd, reg_index, write_data, drive_unit, media_mounted,
                  output ready);
endinterface

interface dcrb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dcrb_pkg::DATA_W-1:0]  read_data;
    logic                         irq_request;
    logic                         irq_cancel;
    logic                         xfer_valid;
    logic                         xfer_write;
    logic [dcrb_pkg::SECT_W-1:0]  xfer_sector;
    logic [dcrb_pkg::BA_W-1:0]    xfer_bus_addr;
    logic [dcrb_pkg::DATA_W-1:0]  xfer_words;

    modport source (output valid, read_data, irq_request, irq_cancel, xfer_valid,
                    xfer_write, xfer_sector, xfer_bus_addr, xfer_words,
                    input ready);
    modport sink (input valid, read_data, irq_request, irq_cancel, xfer_valid,
                  xfer_write, xfer_sector, xfer_bus_addr, xfer_words,
                  output ready);
endinterface

interface dcrb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dcrb_pkg::DELAY_W-1:0]  irq_delay;

    modport source (output valid, irq_delay, input ready);
    modport sink (input valid, irq_delay, output ready);
endinterface

// ----- src/dcrb_xfer_calc.sv -----
// address unit: checks, descriptor and advanced addresses for a read or write
`timescale 1ns / 1ps

module dcrb_xfer_calc (
    input  logic [dcrb_pkg::DATA_W-1:0] disk_addr,
    input  logic [dcrb_pkg::DATA_W-1:0] word_count,
    input  logic [dcrb_pkg::DATA_W-1:0] base_addr,
    input  logic [1:0]                  base_addr_hi,
    output dcrb_pkg::xfer_calc_t        calc
);
    import dcrb_pkg::*;

    logic [7:0]        cyl;
    logic              surf;
    logic [3:0]        sec;
    logic [DATA_W-1:0] words;
    logic [BA_W-1:0]   ba_start;
    logic [8:0]        sec_sum;
    logic [15:0]       div_prod;
    logic [4:0]        quot;
    logic [8:0]        rem_full;
    logic [5:0]        surf_sum;
    logic [7:0]        cyl_next;
    logic [8:0]        track;

    assign cyl   = disk_addr[12:5];
    assign surf  = disk_addr[4];
    assign sec   = disk_addr[3:0];
    assign words = DATA_W'(~word_count + 16'd1);
    assign ba_start = {base_addr_hi, base_addr};
    assign track = {cyl, surf};

    // advance the disk address by the whole sectors moved (words * 2 / 512), carrying into surface and cylinder
    assign sec_sum  = {5'b0, sec} + {1'b0, words[15:8]};
    assign div_prod = {7'b0, sec_sum} * {8'b0, DIV12_MUL};
    assign quot     = div_prod[15:11];
    assign rem_full = sec_sum - (9'({quot, 3'b0}) + 9'({quot, 2'b0}));
    assign surf_sum = {5'b0, surf} + {1'b0, quot};
    assign cyl_next = cyl + {3'b0, surf_sum[5:1]};

    always_comb
    begin
        calc.err_nxc    = cyl > MAX_CYL;
        calc.err_nxs    = sec >= SECS;
        calc.zero_words = words == '0;
        calc.sector     = 13'({1'b0, track, 3'b0}) + 13'({2'b0, track, 2'b0})
                          + 13'(sec);
        calc.start_addr = ba_start;
        calc.words      = words;
        calc.next_wcount    = word_count + words;
        calc.next_addr      = ba_start + {1'b0, words, 1'b0};
        calc.next_disk_addr = {disk_addr[15:13], cyl_next, surf_sum[0], rem_full[3:0]};
    end

endmodule

// ----- src/dcrb_core.sv -----
// register state and command decode, one item per update
`timescale 1ns / 1ps

module dcrb_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  dcrb_pkg::item_t              item,
    input  logic [dcrb_pkg::DELAY_W-1:0] irq_delay,
    output dcrb_pkg::result_t            result
);
    import dcrb_pkg::*;

    logic [DATA_W-1:0]  error_reg, error_next;
    logic [DATA_W-1:0]  control_reg, control_next;
    logic [DATA_W-1:0]  wcount_reg, wcount_next;
    logic [DATA_W-1:0]  busaddr_reg, busaddr_next;
    logic [DATA_W-1:0]  diskaddr_reg, diskaddr_next;
    logic [DELAY_W-1:0] countdown_reg, countdown_next;
    logic               mounted_reg, mounted_next;

    logic [DATA_W-1:0]  ctrl_wr;
    logic [2:0]         func;
    logic               drive_ok;
    xfer_calc_t         calc;

    // control value as written, before the function runs
    assign ctrl_wr  = ((control_reg & CS_KEEP_MASK) | (item.write_data & CS_WR_MASK))
                      & ~CS_RDY;
    assign func     = ctrl_wr[3:1];
    assign drive_ok = (diskaddr_reg[15:13] == 3'd0) && mounted_reg;

    dcrb_xfer_calc u_calc (
        .disk_addr    (diskaddr_reg),
        .word_count   (wcount_reg),
        .base_addr    (busaddr_reg),
        .base_addr_hi (ctrl_wr[5:4]),
        .calc         (calc)
    );

    always_comb
    begin
        error_next     = error_reg;
        control_next   = control_reg;
        wcount_next    = wcount_reg;
        busaddr_next   = busaddr_reg;
        diskaddr_next  = diskaddr_reg;
        countdown_next = countdown_reg;
        mounted_next   = mounted_reg;
        result         = '0;

        unique case (item.cmd)
            CMD_READ:
            begin
                unique case (item.reg_index)
                    REG_STATUS:
                    begin
                        if (diskaddr_reg[15:13] == 3'd0)
                            result.read_data = STATUS_BASE | (mounted_reg ? STATUS_MNT : '0);
                    end
                    REG_ERROR:   result.read_data = error_reg;
                    REG_CONTROL: result.read_data = control_reg;
                    REG_WCOUNT:  result.read_data = wcount_reg;
                    REG_BUSADDR: result.read_data = busaddr_reg;
                    REG_DISKADR: result.read_data = diskaddr_reg;
                    // maintenance and data buffer read as zero
                    default:     result.read_data = '0;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_index)
                    REG_CONTROL:
                    begin
                        if (!item.write_data[0])
                            control_next = ctrl_wr | CS_RDY;
                        else if (func == FN_CTRL_RESET)
                        begin
                            error_next     = '0;
                            control_next   = CS_RDY;
                            wcount_next    = '0;
                            busaddr_next   = '0;
                            diskaddr_next  = '0;
                            countdown_next = '0;
                            result.irq_cancel = 1'b1;
                        end
                        else
                        begin
                            error_next   = '0;
                            control_next = ctrl_wr;
                            if (!drive_ok)
                            begin
                                error_next   = ERR_NXD;
                                control_next = ctrl_wr | CS_ERR;
                            end
                            else if (func == FN_WRITE || func == FN_READ)
                            begin
                                if (calc.err_nxc)
                                begin
                                    error_next   = ERR_NXC;
                                    control_next = ctrl_wr | CS_ERR;
                                end
                                else if (calc.err_nxs)
                                begin
                                    error_next   = ERR_NXS;
                                    control_next = ctrl_wr | CS_ERR;
                                end
                                else if (!calc.zero_words)
                                begin
                                    result.xfer_valid    = 1'b1;
                                    result.xfer_write    = func == FN_WRITE;
                                    result.xfer_sector   = calc.sector;
                                    result.xfer_bus_addr = calc.start_addr;
                                    result.xfer_words    = calc.words;
                                    wcount_next   = calc.next_wcount;
                                    busaddr_next  = calc.next_addr[15:0];
                                    diskaddr_next = calc.next_disk_addr;
                                    control_next[5:4] = calc.next_addr[17:16];
                                end
                            end
                            control_next = control_next | CS_RDY;
                            if (control_next[CS_IE_BIT])
                                countdown_next = irq_delay;
                        end
                    end
                    REG_WCOUNT:  wcount_next   = item.write_data;
                    REG_BUSADDR: busaddr_next  = item.write_data;
                    REG_DISKADR: diskaddr_next = item.write_data;
                    default:     ;
                endcase
            end
            CMD_TICK:
            begin
                if (countdown_reg != '0)
                begin
                    countdown_next = countdown_reg - 1'b1;
                    if (countdown_reg == DELAY_W'(1) && control_reg[CS_IE_BIT])
                        result.irq_request = 1'b1;
                end
            end
            CMD_MEDIA:
            begin
                if (item.drive_unit == '0)
                    mounted_next = item.media_mounted;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_reg     <= '0;
            control_reg   <= CS_RDY;
            wcount_reg    <= '0;
            busaddr_reg   <= '0;
            diskaddr_reg  <= '0;
            countdown_reg <= '0;
            mounted_reg   <= 1'b0;
        end
        else if (fire)
        begin
            error_reg     <= error_next;
            control_reg   <= control_next;
            wcount_reg    <= wcount_next;
            busaddr_reg   <= busaddr_next;
            diskaddr_reg  <= diskaddr_next;
            countdown_reg <= countdown_next;
            mounted_reg   <= mounted_next;
        end
    end

endmodule

// ----- src/disk_controller_register_block.sv -----
// top level of the disk controller register block
//
//  channel  direction  contents
//  req      in         cmd, reg_index, write_data, drive_unit, media_mounted
//  rsp      out        read_data, irq_request, irq_cancel, xfer descriptor
//  cfg      in         irq_delay
//
// one item per cycle sustained while rsp is ready; an accepted item passes the input register,
// then the result register after the register update logic
// reset loads the controller registers at once, no clearing pass
// a stalled rsp holds the result register; req keeps flowing while the input
// register can move forward, and cfg is always ready
`timescale 1ns / 1ps

module disk_controller_register_block (
    input logic        clk,
    input logic        rst_n,
    dcrb_req_if.sink   req,
    dcrb_rsp_if.source rsp,
    dcrb_cfg_if.sink   cfg
);
    import dcrb_pkg::*;

    logic               in_valid_reg;
    item_t              item_reg;
    logic               out_valid_reg;
    result_t            res_reg;
    logic [DELAY_W-1:0] irq_delay_reg;
    logic               advance;
    logic               req_fire;
    result_t            core_res;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    dcrb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (item_reg),
        .irq_delay (irq_delay_reg),
        .result    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            irq_delay_reg <= IRQ_DELAY_RST;
        end
        else
        begin
            if (req_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
                irq_delay_reg <= cfg.irq_delay;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.cmd           <= req.cmd;
            item_reg.reg_index     <= req.reg_index;
            item_reg.write_data    <= req.write_data;
            item_reg.drive_unit    <= req.drive_unit;
            item_reg.media_mounted <= req.media_mounted;
        end
        if (advance)
            res_reg <= core_res;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = res_reg.read_data;
    assign rsp.irq_request   = res_reg.irq_request;
    assign rsp.irq_cancel    = res_reg.irq_cancel;
    assign rsp.xfer_valid    = res_reg.xfer_valid;
    assign rsp.xfer_write    = res_reg.xfer_write;
    assign rsp.xfer_sector   = res_reg.xfer_sector;
    assign rsp.xfer_bus_addr = res_reg.xfer_bus_addr;
    assign rsp.xfer_words    = res_reg.xfer_words;

endmodule

// ----- src/dcrb_checker.sv -----
// port checks of the disk controller register block and their binding
`timescale 1ns / 1ps

module dcrb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [dcrb_pkg::DATA_W-1:0]  read_data,
    input logic                         irq_request,
    input logic                         irq_cancel,
    input logic                         xfer_valid,
    input logic                         xfer_write,
    input logic [dcrb_pkg::SECT_W-1:0]  xfer_sector,
    input logic [dcrb_pkg::BA_W-1:0]    xfer_bus_addr,
    input logic [dcrb_pkg::DATA_W-1:0]  xfer_words
);
    import dcrb_pkg::*;

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(xfer_words))
        else $error("stalled result changed");

    // no descriptor, no descriptor fields
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !xfer_valid |-> !xfer_write && xfer_sector == '0
            && xfer_bus_addr == '0 && xfer_words == '0)
        else $error("descriptor fields set without a descriptor");

    // an issued descriptor always moves data inside the disk geometry
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && xfer_valid |-> xfer_words != '0 && xfer_sector <= 13'd4871)
        else $error("descriptor out of range");

    // one item never both raises and withdraws the interrupt, nor mixes with a descriptor or read data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (irq_request || irq_cancel) |-> !(irq_request && irq_cancel)
            && !xfer_valid && read_data == '0)
        else $error("interrupt pulse mixed with other results");

endmodule

bind disk_controller_register_block dcrb_checker u_dcrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .read_data     (rsp.read_data),
    .irq_request   (rsp.irq_request),
    .irq_cancel    (rsp.irq_cancel),
    .xfer_valid    (rsp.xfer_valid),
    .xfer_write    (rsp.xfer_write),
    .xfer_sector   (rsp.xfer_sector),
    .xfer_bus_addr (rsp.xfer_bus_addr),
    .xfer_words    (rsp.xfer_words)
);
